### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the extremum analyzer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SEA_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed in sample extremum analyzer");

// Condition that must hold at every rising clock edge outside reset.
`define SEA_ASSERT_ALWAYS(label, clk, rstn, expr) \
    `SEA_ASSERT_CLK(label, clk, rstn, (expr))

`endif

### rtl/sea_pkg.sv
// Package of the sample extremum analyzer: widths, limits and result codes.
package sea_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int CURVE_W  = 2;

    localparam logic [INDEX_W-1:0] INDEX_TOP = {INDEX_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_MIN  = 2'd1,
        MARK_MAX  = 2'd2
    } mark_t;

    localparam logic [CURVE_W-1:0] CURVE_NONMONO    = 2'd0;
    localparam logic [CURVE_W-1:0] CURVE_GROWING    = 2'd1;
    localparam logic [CURVE_W-1:0] CURVE_DECREASING = 2'd2;

endpackage

### rtl/sample_extremum_analyzer_unit.sv
// Top level of the sample extremum analyzer: local and global extremum tracking.
//
// Usage: samples enter on the s_ channel (s_sample, s_last) under valid/ready;
// one result item per sample leaves on the m_ channel under valid/ready.
// Each result gives the local mark (minimum, maximum or none) for the sample
// one position back. The result of the item flagged last also carries the
// global minimum and maximum with their first indices, the curve type and
// the swing count; these fields are zero on other results.
// A result is valid in the cycle after its sample is accepted.
// Throughput: one item per cycle while m_ready is high, set by the single result register; the
// window compare and counter update fit between the state and that register.
// s_ready is high while the result register is empty or being drained, so a
// stalled receiver holds the pending result and stops intake after one item.
// Reset (aresetn low, synchronous) empties the result register and clears the
// window, index, global extremes and counts. The same state clears after each
// sample flagged last, so the next sample starts a new sequence at index 0.
module sample_extremum_analyzer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sea_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [sea_pkg::INDEX_W-1:0]  m_mark_position,
    output logic        [1:0]                   m_mark,
    output logic signed [sea_pkg::SAMPLE_W-1:0] m_low_value,
    output logic        [sea_pkg::INDEX_W-1:0]  m_low_index,
    output logic signed [sea_pkg::SAMPLE_W-1:0] m_high_value,
    output logic        [sea_pkg::INDEX_W-1:0]  m_high_index,
    output logic        [sea_pkg::CURVE_W-1:0]  m_curve_type,
    output logic        [sea_pkg::COUNT_W-1:0]  m_swing_count,
    output logic                                m_done_res
);

    `include "assert_macros.svh"

    // Sequence state.
    logic signed [sea_pkg::SAMPLE_W-1:0] older_reg, newer_reg;
    logic        [sea_pkg::INDEX_W-1:0]  index_reg;
    logic signed [sea_pkg::SAMPLE_W-1:0] low_best_reg, high_best_reg;
    logic        [sea_pkg::INDEX_W-1:0]  low_idx_reg, high_idx_reg;
    logic        [sea_pkg::COUNT_W-1:0]  min_cnt_reg, max_cnt_reg;
    logic                                low_loc_reg, high_loc_reg;

    logic signed [sea_pkg::SAMPLE_W-1:0] low_best_next, high_best_next;
    logic        [sea_pkg::INDEX_W-1:0]  low_idx_next, high_idx_next;
    logic        [sea_pkg::INDEX_W-1:0]  index_next;
    logic        [sea_pkg::COUNT_W-1:0]  min_cnt_next, max_cnt_next;
    logic                                low_loc_next, high_loc_next;

    // Result register.
    logic                                valid_reg;
    logic        [sea_pkg::INDEX_W-1:0]  pos_reg;
    sea_pkg::mark_t                      mark_reg;
    logic signed [sea_pkg::SAMPLE_W-1:0] low_val_reg, high_val_reg;
    logic        [sea_pkg::INDEX_W-1:0]  low_out_reg, high_out_reg;
    logic        [sea_pkg::CURVE_W-1:0]  curve_reg;
    logic        [sea_pkg::COUNT_W-1:0]  swing_reg;
    logic                                done_reg;

    logic                                accept;
    logic        [sea_pkg::INDEX_W-1:0]  pos;
    logic                                is_min, is_max, same_pos;
    sea_pkg::mark_t                      mark;
    logic        [sea_pkg::COUNT_W:0]    minima, maxima, swing_wide, marks_sum, locals_sum;
    logic        [sea_pkg::COUNT_W-1:0]  swing;
    logic        [sea_pkg::CURVE_W-1:0]  curve;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos = (index_reg != '0) ? index_reg - 1'b1 : '0;
        is_min = (index_reg > 16'd1) && (newer_reg < older_reg) && (newer_reg < s_sample);
        is_max = (index_reg > 16'd1) && !is_min
                 && (newer_reg > older_reg) && (newer_reg > s_sample);
        if (is_min) begin
            mark = sea_pkg::MARK_MIN;
        end else if (is_max) begin
            mark = sea_pkg::MARK_MAX;
        end else begin
            mark = sea_pkg::MARK_NONE;
        end

        min_cnt_next = (is_min && min_cnt_reg != sea_pkg::COUNT_TOP)
                       ? min_cnt_reg + 1'b1 : min_cnt_reg;
        max_cnt_next = (is_max && max_cnt_reg != sea_pkg::COUNT_TOP)
                       ? max_cnt_reg + 1'b1 : max_cnt_reg;
        low_loc_next  = low_loc_reg || (is_min && low_idx_reg == pos);
        high_loc_next = high_loc_reg || (is_max && high_idx_reg == pos);

        low_best_next = low_best_reg;
        low_idx_next  = low_idx_reg;
        if (index_reg == '0 || s_sample < low_best_reg) begin
            low_best_next = s_sample;
            low_idx_next  = index_reg;
            low_loc_next  = 1'b0;
        end
        high_best_next = high_best_reg;
        high_idx_next  = high_idx_reg;
        if (index_reg == '0 || s_sample > high_best_reg) begin
            high_best_next = s_sample;
            high_idx_next  = index_reg;
            high_loc_next  = 1'b0;
        end

        index_next = (index_reg < sea_pkg::INDEX_TOP) ? index_reg + 1'b1 : index_reg;

        // A global extreme that is also a local one is counted once.
        same_pos = (low_idx_next == high_idx_next);
        minima = {1'b0, min_cnt_next} - {16'd0, low_loc_next} + {16'd0, !same_pos};
        maxima = {1'b0, max_cnt_next} - {16'd0, high_loc_next} + 17'd1;
        swing_wide = (minima < maxima) ? minima : maxima;
        swing = swing_wide[sea_pkg::COUNT_W] ? sea_pkg::COUNT_TOP
                                             : swing_wide[sea_pkg::COUNT_W-1:0];
        marks_sum  = {1'b0, min_cnt_next} + {1'b0, max_cnt_next};
        locals_sum = {16'd0, low_loc_next} + {16'd0, high_loc_next};
        if (!same_pos && marks_sum == locals_sum) begin
            curve = (low_idx_next < high_idx_next) ? sea_pkg::CURVE_GROWING
                                                   : sea_pkg::CURVE_DECREASING;
        end else begin
            curve = sea_pkg::CURVE_NONMONO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg     <= '0;
            newer_reg     <= '0;
            index_reg     <= '0;
            low_best_reg  <= '0;
            low_idx_reg   <= '0;
            high_best_reg <= '0;
            high_idx_reg  <= '0;
            min_cnt_reg   <= '0;
            max_cnt_reg   <= '0;
            low_loc_reg   <= 1'b0;
            high_loc_reg  <= 1'b0;
        end else if (accept) begin
            if (s_last) begin
                older_reg     <= '0;
                newer_reg     <= '0;
                index_reg     <= '0;
                low_best_reg  <= '0;
                low_idx_reg   <= '0;
                high_best_reg <= '0;
                high_idx_reg  <= '0;
                min_cnt_reg   <= '0;
                max_cnt_reg   <= '0;
                low_loc_reg   <= 1'b0;
                high_loc_reg  <= 1'b0;
            end else begin
                older_reg     <= newer_reg;
                newer_reg     <= s_sample;
                index_reg     <= index_next;
                low_best_reg  <= low_best_next;
                low_idx_reg   <= low_idx_next;
                high_best_reg <= high_best_next;
                high_idx_reg  <= high_idx_next;
                min_cnt_reg   <= min_cnt_next;
                max_cnt_reg   <= max_cnt_next;
                low_loc_reg   <= low_loc_next;
                high_loc_reg  <= high_loc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg      <= pos;
            mark_reg     <= mark;
            done_reg     <= s_last;
            low_val_reg  <= s_last ? low_best_next : '0;
            low_out_reg  <= s_last ? low_idx_next : '0;
            high_val_reg <= s_last ? high_best_next : '0;
            high_out_reg <= s_last ? high_idx_next : '0;
            curve_reg    <= s_last ? curve : sea_pkg::CURVE_NONMONO;
            swing_reg    <= s_last ? swing : '0;
        end
    end

    assign m_valid         = valid_reg;
    assign m_mark_position = pos_reg;
    assign m_mark          = mark_reg;
    assign m_low_value     = low_val_reg;
    assign m_low_index     = low_out_reg;
    assign m_high_value    = high_val_reg;
    assign m_high_index    = high_out_reg;
    assign m_curve_type    = curve_reg;
    assign m_swing_count   = swing_reg;
    assign m_done_res      = done_reg;

    `SEA_ASSERT_CLK(a_clear_after_last, aclk, aresetn,
        accept && s_last |=> index_reg == '0 && min_cnt_reg == '0 && max_cnt_reg == '0)
    `SEA_ASSERT_CLK(a_index_steps, aclk, aresetn,
        accept && !s_last && index_reg != sea_pkg::INDEX_TOP
        |=> index_reg == $past(index_reg) + 1'b1)
    `SEA_ASSERT_CLK(a_mark_needs_window, aclk, aresetn,
        valid_reg && mark_reg != sea_pkg::MARK_NONE |-> pos_reg != '0)
    `SEA_ASSERT_CLK(a_summary_only_done, aclk, aresetn,
        valid_reg && !done_reg |-> curve_reg == sea_pkg::CURVE_NONMONO && swing_reg == '0)
    `SEA_ASSERT_ALWAYS(a_one_mark, aclk, aresetn, !(is_min && is_max))

endmodule
